>>> sv/amgs_pkg.sv
// ----------------------------------------------------------------------------
// amgs_pkg: shared types and constants of the adjacency matrix graph store
// Sizes, action and status codes, and the memory request bundles that pass
// between the sequencer and the top level.
// ----------------------------------------------------------------------------
package amgs_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VIDX_W       = 6;
   localparam int VCNT_W       = 7;
   localparam int MAT_AW       = 2 * VIDX_W;
   localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
   localparam int WEIGHT_W     = 32;
   localparam int DEG_W        = 6;
   localparam int EDGE_W       = 12;

   localparam logic [EDGE_W-1:0] DEG_MAX  = 12'd63;
   localparam logic [EDGE_W-1:0] EDGE_MAX = 12'd4095;

   localparam logic [2:0] ACT_CLEAR       = 3'd0;
   localparam logic [2:0] ACT_ADD_VERTEX  = 3'd1;
   localparam logic [2:0] ACT_ADD_EDGE    = 3'd2;
   localparam logic [2:0] ACT_REMOVE_EDGE = 3'd3;
   localparam logic [2:0] ACT_SET_WEIGHT  = 3'd4;
   localparam logic [2:0] ACT_QUERY       = 3'd5;
   localparam logic [2:0] ACT_NEXT_NEIGH  = 3'd6;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic                we;
      logic [MAT_AW-1:0]   waddr;
      logic [WEIGHT_W-1:0] wdata;
      logic [MAT_AW-1:0]   raddr;
   } mat_req_type;

   typedef struct packed {
      logic              we;
      logic [VIDX_W-1:0] waddr;
      logic [DEG_W-1:0]  wdata;
      logic [VIDX_W-1:0] raddr;
   } deg_req_type;

endpackage

>>> sv/amgs_ram.sv
// ----------------------------------------------------------------------------
// amgs_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module amgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/amgs_step.sv
// ----------------------------------------------------------------------------
// amgs_step: saturating up/down step unit
// Shared by the degree counters and the edge counter.
// ----------------------------------------------------------------------------
module amgs_step (
   input  logic [amgs_pkg::EDGE_W-1:0] value,
   input  logic [amgs_pkg::EDGE_W-1:0] limit,
   input  logic                        up,
   output logic [amgs_pkg::EDGE_W-1:0] result
);

   always_comb begin
      result = value;
      if (up) begin
         if (value < limit) begin
            result = value + 12'd1;
         end
      end else begin
         if (value != '0) begin
            result = value - 12'd1;
         end
      end
   end

endmodule

>>> sv/amgs_seq.sv
// ----------------------------------------------------------------------------
// amgs_seq: action sequencer
// Walks each action through the matrix and degree memories, one memory
// access per port per cycle, and holds the vertex and edge counters.
// ----------------------------------------------------------------------------
module amgs_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_action,
   input  logic [amgs_pkg::VIDX_W-1:0]          req_vertex_a,
   input  logic [amgs_pkg::VIDX_W-1:0]          req_vertex_b,
   input  logic signed [amgs_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  logic                                 req_scan_from_start,
   input  logic [amgs_pkg::WEIGHT_W-1:0]        null_weight,
   output amgs_pkg::mat_req_type                mat_req,
   input  logic [amgs_pkg::WEIGHT_W-1:0]        mat_rdata,
   output amgs_pkg::deg_req_type                deg_req,
   input  logic [amgs_pkg::DEG_W-1:0]           deg_rdata,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic signed [amgs_pkg::WEIGHT_W-1:0] rsp_pair_weight,
   output logic                                 rsp_edge_exists,
   output logic [amgs_pkg::DEG_W-1:0]           rsp_degree_of_a,
   output logic [amgs_pkg::VCNT_W-1:0]          rsp_vertices_in_use,
   output logic [amgs_pkg::EDGE_W-1:0]          rsp_edges_in_use,
   output logic [amgs_pkg::VIDX_W-1:0]          rsp_neighbour_index,
   output logic                                 rsp_neighbour_found
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SWEEP   = 4'd1;
   localparam logic [3:0] ST_NEW_DEG = 4'd2;
   localparam logic [3:0] ST_WR_AB   = 4'd3;
   localparam logic [3:0] ST_WR_BA   = 4'd4;
   localparam logic [3:0] ST_RD_B    = 4'd5;
   localparam logic [3:0] ST_UPD_B   = 4'd6;
   localparam logic [3:0] ST_EDGE    = 4'd7;
   localparam logic [3:0] ST_QRY     = 4'd8;
   localparam logic [3:0] ST_QCHK    = 4'd9;
   localparam logic [3:0] ST_SCAN    = 4'd10;
   localparam logic [3:0] ST_RD_DEG  = 4'd11;
   localparam logic [3:0] ST_OUT     = 4'd12;

   localparam int SWEEP_W = amgs_pkg::VIDX_W + 1;

   logic [3:0]                         state_ff, state_in;
   logic [2:0]                         op_ff, op_in;
   logic [amgs_pkg::VIDX_W-1:0]        a_ff, a_in;
   logic [amgs_pkg::VIDX_W-1:0]        b_ff, b_in;
   logic [amgs_pkg::WEIGHT_W-1:0]      wdat_ff, wdat_in;
   logic [SWEEP_W-1:0]                 cnt_ff, cnt_in;
   logic [amgs_pkg::VCNT_W-1:0]        issue_ff, issue_in;
   logic                               chk_valid_ff, chk_valid_in;
   logic [amgs_pkg::VIDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic [amgs_pkg::VCNT_W-1:0]        vtot_ff, vtot_in;
   logic [amgs_pkg::EDGE_W-1:0]        etot_ff, etot_in;
   logic [1:0]                         status_ff, status_in;
   logic [amgs_pkg::WEIGHT_W-1:0]      pw_ff, pw_in;
   logic                               exists_ff, exists_in;
   logic [amgs_pkg::VIDX_W-1:0]        nidx_ff, nidx_in;
   logic                               nfound_ff, nfound_in;

   logic                               valid_a_req;
   logic                               valid_b_req;
   logic                               weight_differs;
   logic [amgs_pkg::VIDX_W-1:0]        new_vertex;
   logic [amgs_pkg::EDGE_W-1:0]        step_value;
   logic [amgs_pkg::EDGE_W-1:0]        step_limit;
   logic [amgs_pkg::EDGE_W-1:0]        step_result;

   assign valid_a_req    = {1'b0, req_vertex_a} < vtot_ff;
   assign valid_b_req    = {1'b0, req_vertex_b} < vtot_ff;
   assign weight_differs = mat_rdata != null_weight;
   assign new_vertex     = vtot_ff[amgs_pkg::VIDX_W-1:0];

   // The edge counter and both degree counters share one step unit.
   assign step_value = (state_ff == ST_EDGE) ? etot_ff
                                             : {{(amgs_pkg::EDGE_W-amgs_pkg::DEG_W){1'b0}},
                                                deg_rdata};
   assign step_limit = (state_ff == ST_EDGE) ? amgs_pkg::EDGE_MAX : amgs_pkg::DEG_MAX;

   amgs_step u_step (
      .value  (step_value),
      .limit  (step_limit),
      .up     (op_ff == amgs_pkg::ACT_ADD_EDGE),
      .result (step_result)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      wdat_in      = wdat_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      chk_valid_in = chk_valid_ff;
      chk_idx_in   = chk_idx_ff;
      vtot_in      = vtot_ff;
      etot_in      = etot_ff;
      status_in    = status_ff;
      pw_in        = pw_ff;
      exists_in    = exists_ff;
      nidx_in      = nidx_ff;
      nfound_in    = nfound_ff;

      mat_req.we    = 1'b0;
      mat_req.waddr = {a_ff, b_ff};
      mat_req.wdata = wdat_ff;
      mat_req.raddr = {a_ff, b_ff};
      deg_req.we    = 1'b0;
      deg_req.waddr = a_ff;
      deg_req.wdata = step_result[amgs_pkg::DEG_W-1:0];
      deg_req.raddr = a_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in        = req_action;
               a_in         = req_vertex_a;
               b_in         = req_vertex_b;
               wdat_in      = (req_action == amgs_pkg::ACT_REMOVE_EDGE) ? null_weight
                                                                        : req_edge_weight;
               cnt_in       = '0;
               issue_in     = req_scan_from_start ? '0
                                                  : {1'b0, req_vertex_b} + 7'd1;
               chk_valid_in = 1'b0;
               status_in    = amgs_pkg::STATUS_OK;
               pw_in        = '0;
               exists_in    = 1'b0;
               nidx_in      = '0;
               nfound_in    = 1'b0;
               state_in     = ST_RD_DEG;
               case (req_action)
                  amgs_pkg::ACT_CLEAR: begin
                     vtot_in = '0;
                     etot_in = '0;
                  end
                  amgs_pkg::ACT_ADD_VERTEX: begin
                     if (vtot_ff >= amgs_pkg::VCNT_W'(amgs_pkg::MAX_VERTICES)) begin
                        status_in = amgs_pkg::STATUS_FULL;
                     end else begin
                        state_in = ST_SWEEP;
                     end
                  end
                  amgs_pkg::ACT_ADD_EDGE,
                  amgs_pkg::ACT_REMOVE_EDGE,
                  amgs_pkg::ACT_SET_WEIGHT: begin
                     if (valid_a_req && valid_b_req) begin
                        state_in = ST_WR_AB;
                     end else begin
                        status_in = amgs_pkg::STATUS_INVALID;
                     end
                  end
                  amgs_pkg::ACT_QUERY: begin
                     if (valid_a_req && valid_b_req) begin
                        state_in = ST_QRY;
                     end else begin
                        status_in = amgs_pkg::STATUS_INVALID;
                     end
                  end
                  amgs_pkg::ACT_NEXT_NEIGH: begin
                     if (valid_a_req) begin
                        state_in = ST_SCAN;
                     end else begin
                        status_in = amgs_pkg::STATUS_INVALID;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Even counts null the new vertex's row entry, odd counts its column entry.
         ST_SWEEP: begin
            mat_req.we    = 1'b1;
            mat_req.wdata = null_weight;
            mat_req.waddr = cnt_ff[0] ? {cnt_ff[SWEEP_W-1:1], new_vertex}
                                      : {new_vertex, cnt_ff[SWEEP_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_NEW_DEG;
            end
         end

         ST_NEW_DEG: begin
            deg_req.we    = 1'b1;
            deg_req.waddr = new_vertex;
            deg_req.wdata = '0;
            vtot_in       = vtot_ff + 1'b1;
            state_in      = ST_RD_DEG;
         end

         ST_WR_AB: begin
            mat_req.we = 1'b1;
            state_in   = ST_WR_BA;
         end

         ST_WR_BA: begin
            mat_req.we    = 1'b1;
            mat_req.waddr = {b_ff, a_ff};
            if (op_ff == amgs_pkg::ACT_SET_WEIGHT) begin
               state_in = ST_RD_DEG;
            end else begin
               deg_req.we = 1'b1;
               state_in   = ST_RD_B;
            end
         end

         // The read of b waits for a's update so that a self loop counts twice.
         ST_RD_B: begin
            deg_req.raddr = b_ff;
            state_in      = ST_UPD_B;
         end

         ST_UPD_B: begin
            deg_req.we    = 1'b1;
            deg_req.waddr = b_ff;
            state_in      = ST_EDGE;
         end

         ST_EDGE: begin
            etot_in  = step_result;
            state_in = ST_RD_DEG;
         end

         ST_QRY: begin
            state_in = ST_QCHK;
         end

         ST_QCHK: begin
            pw_in     = mat_rdata;
            exists_in = weight_differs;
            state_in  = ST_RD_DEG;
         end

         // One read is issued per cycle while the previous one is checked.
         ST_SCAN: begin
            mat_req.raddr = {a_ff, issue_ff[amgs_pkg::VIDX_W-1:0]};
            if (chk_valid_ff && weight_differs) begin
               nidx_in   = chk_idx_ff;
               nfound_in = 1'b1;
               state_in  = ST_RD_DEG;
            end else if (issue_ff < vtot_ff) begin
               issue_in     = issue_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff[amgs_pkg::VIDX_W-1:0];
            end else if (chk_valid_ff) begin
               chk_valid_in = 1'b0;
            end else begin
               state_in = ST_RD_DEG;
            end
         end

         ST_RD_DEG: begin
            state_in = ST_OUT;
         end

         ST_OUT: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vtot_ff      <= '0;
         etot_ff      <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vtot_ff      <= vtot_in;
         etot_ff      <= etot_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      wdat_ff    <= wdat_in;
      cnt_ff     <= cnt_in;
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      pw_ff      <= pw_in;
      exists_ff  <= exists_in;
      nidx_ff    <= nidx_in;
      nfound_ff  <= nfound_in;
   end

   assign busy                = state_ff != ST_IDLE;
   assign rsp_strobe          = state_ff == ST_OUT;
   assign rsp_status          = status_ff;
   assign rsp_pair_weight     = pw_ff;
   assign rsp_edge_exists     = exists_ff;
   assign rsp_degree_of_a     = ({1'b0, a_ff} < vtot_ff) ? deg_rdata : '0;
   assign rsp_vertices_in_use = vtot_ff;
   assign rsp_edges_in_use    = etot_ff;
   assign rsp_neighbour_index = nidx_ff;
   assign rsp_neighbour_found = nfound_ff;

endmodule

>>> sv/adjacency_matrix_graph_store.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store: undirected weighted graph in an adjacency matrix
// Holds a 64 x 64 weight matrix and per-vertex degrees in RAM, runs one
// action per item under a sequencer and reports one result per item.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                         Payload
//   --------  --------------------------------  --------------------------------
//   request   start high while busy low         req_action .. req_scan_from_start
//   result    rsp_strobe high for one cycle     rsp_status .. rsp_neighbour_found
//   config    psel, penable, pwrite, pready     paddr, pwdata (null weight)
//
// Each item runs from the accepting edge to the end of its strobe cycle. Clear, no-op,
// full and bad-index items go straight to the result; query and set weight access the
// matrix pair; add and remove edge also step both degrees and the edge count; a scan
// reads the matrix once per cycle. A new vertex sweeps its row and column, 128 writes.
// Reset is synchronous and clears the counters; the memories need no clearing.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_action,
   input  logic [amgs_pkg::VIDX_W-1:0]          req_vertex_a,
   input  logic [amgs_pkg::VIDX_W-1:0]          req_vertex_b,
   input  logic signed [amgs_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  logic                                 req_scan_from_start,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic signed [amgs_pkg::WEIGHT_W-1:0] rsp_pair_weight,
   output logic                                 rsp_edge_exists,
   output logic [amgs_pkg::DEG_W-1:0]           rsp_degree_of_a,
   output logic [amgs_pkg::VCNT_W-1:0]          rsp_vertices_in_use,
   output logic [amgs_pkg::EDGE_W-1:0]          rsp_edges_in_use,
   output logic [amgs_pkg::VIDX_W-1:0]          rsp_neighbour_index,
   output logic                                 rsp_neighbour_found,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   logic [amgs_pkg::WEIGHT_W-1:0] null_weight_ff, null_weight_in;
   logic                          csr_hit;

   amgs_pkg::mat_req_type         mat_req;
   amgs_pkg::deg_req_type         deg_req;
   logic [amgs_pkg::WEIGHT_W-1:0] mat_rdata;
   logic [amgs_pkg::DEG_W-1:0]    deg_rdata;

   assign pready  = 1'b1;
   assign csr_hit = paddr == 3'd0;

   always_comb begin
      null_weight_in = null_weight_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         null_weight_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         null_weight_ff <= '0;
      end else begin
         null_weight_ff <= null_weight_in;
      end
   end

   assign prdata = csr_hit ? null_weight_ff : '0;

   amgs_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_vertex_a        (req_vertex_a),
      .req_vertex_b        (req_vertex_b),
      .req_edge_weight     (req_edge_weight),
      .req_scan_from_start (req_scan_from_start),
      .null_weight         (null_weight_ff),
      .mat_req             (mat_req),
      .mat_rdata           (mat_rdata),
      .deg_req             (deg_req),
      .deg_rdata           (deg_rdata),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_pair_weight     (rsp_pair_weight),
      .rsp_edge_exists     (rsp_edge_exists),
      .rsp_degree_of_a     (rsp_degree_of_a),
      .rsp_vertices_in_use (rsp_vertices_in_use),
      .rsp_edges_in_use    (rsp_edges_in_use),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_neighbour_found (rsp_neighbour_found)
   );

   amgs_ram #(
      .WIDTH (amgs_pkg::WEIGHT_W),
      .DEPTH (amgs_pkg::MAT_DEPTH)
   ) u_matrix (
      .clock (clock),
      .we    (mat_req.we),
      .waddr (mat_req.waddr),
      .wdata (mat_req.wdata),
      .raddr (mat_req.raddr),
      .rdata (mat_rdata)
   );

   amgs_ram #(
      .WIDTH (amgs_pkg::DEG_W),
      .DEPTH (amgs_pkg::MAX_VERTICES)
   ) u_degrees (
      .clock (clock),
      .we    (deg_req.we),
      .waddr (deg_req.waddr),
      .wdata (deg_req.wdata),
      .raddr (deg_req.raddr),
      .rdata (deg_rdata)
   );

   // An accepted item always makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item accepted but block not busy");

   // A result ends the item: one strobe per item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe not followed by idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_vertices_in_use <= amgs_pkg::VCNT_W'(amgs_pkg::MAX_VERTICES))
      else $error("vertex count beyond table size");

   // A found neighbour lies inside the current vertex range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_neighbour_found |->
         {1'b0, rsp_neighbour_index} < rsp_vertices_in_use)
      else $error("neighbour index outside vertex range");

endmodule
